// ===== hw/rtl/imh_pkg.sv =====
// Package for the indexed min-heap: entry layout, operation and status codes,
// controller states, and the command and status structs between controller and datapath.
// No dependencies.
package imh_pkg;

  localparam int unsigned DefCapacity = 256;
  localparam int unsigned DefIdCount  = 256;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_ADD    = 3'd2,
    OP_FLAG   = 3'd3,
    OP_WEIGHT = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUP       = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] freq;
    logic        flag;
    logic [15:0] weight;
  } entry_t;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT,
    RD_SLOT
  } rd_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_RD,
    S_POP_LAST,
    S_UPD_SLOT,
    S_UPD_RD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DN_DEC,
    S_WRITE,
    S_TOP,
    S_TOP_RD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    ld_in;
    logic    push_init;
    logic    pop_take;
    logic    pop_last_ld;
    logic    upd_pos_ld;
    logic    upd_e_ld;
    logic    up_move;
    logic    dn_left_ld;
    logic    dn_right_cmp;
    logic    dn_move;
    logic    e_write;
    logic    top_ld;
    logic    out_ld;
    logic    set_status;
    status_e status;
    logic    heap_rd;
    rd_sel_e rd_sel;
    logic    slot_rd;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    id_ok;
    logic    held;
    logic    cnt_zero;
    logic    cnt_full;
    logic    cnt_one;
    logic    pos_zero;
    logic    left_ok;
    logic    right_ok;
    logic    up_ahead;
    logic    child_better;
    logic    dir_up;
    logic    dir_down;
    logic    have_report;
    logic    out_busy;
  } dp_stat_t;

  // True when a ranks ahead of b: lower frequency, then flag set, then lower weight.
  function automatic logic ranks_ahead(entry_t a, entry_t b);
    logic r;
    if (a.freq != b.freq) begin
      r = a.freq < b.freq;
    end else if (a.flag != b.flag) begin
      r = a.flag;
    end else begin
      r = a.weight < b.weight;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/imh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/imh_ctrl.sv =====
// Controller state machine of the indexed min-heap: sequences each operation and the sifts.
// Depends on imh_pkg.
module imh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  imh_pkg::dp_stat_t  stat_i,
  output imh_pkg::ctrl_cmd_t cmd_o
);
  import imh_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (stat_i.op)
          OP_PUSH: begin
            if (stat_i.id_ok && !stat_i.held && !stat_i.cnt_full) state_d = S_UP_RD;
            else state_d = S_TOP;
          end
          OP_POP:  state_d = stat_i.cnt_zero ? S_TOP : S_POP_RD;
          OP_ADD, OP_FLAG, OP_WEIGHT: state_d = stat_i.held ? S_UPD_SLOT : S_TOP;
          default: state_d = S_TOP;
        endcase
      end
      S_POP_RD:   state_d = stat_i.cnt_one ? S_TOP : S_POP_LAST;
      S_POP_LAST: state_d = S_DN_L;
      S_UPD_SLOT: state_d = S_UPD_RD;
      S_UPD_RD: begin
        if (stat_i.dir_up) state_d = S_UP_RD;
        else if (stat_i.dir_down) state_d = S_DN_L;
        else state_d = S_WRITE;
      end
      S_UP_RD:    state_d = stat_i.pos_zero ? S_WRITE : S_UP_CMP;
      S_UP_CMP:   state_d = stat_i.up_ahead ? S_UP_RD : S_WRITE;
      S_DN_L:     state_d = stat_i.left_ok ? S_DN_R : S_WRITE;
      S_DN_R:     state_d = stat_i.right_ok ? S_DN_CMP : S_DN_DEC;
      S_DN_CMP:   state_d = S_DN_DEC;
      S_DN_DEC:   state_d = stat_i.child_better ? S_DN_L : S_WRITE;
      S_WRITE:    state_d = S_TOP;
      S_TOP:      state_d = (stat_i.have_report || stat_i.cnt_zero) ? S_DONE : S_TOP_RD;
      S_TOP_RD:   state_d = S_DONE;
      S_DONE:     if (!stat_i.out_busy) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = ST_OK;
    cmd_o.rd_sel = RD_ZERO;
    case (state_q)
      S_IDLE: cmd_o.ld_in = in_valid_i;
      S_DECODE: begin
        case (stat_i.op)
          OP_PUSH: begin
            if (!stat_i.id_ok) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NOT_FOUND;
            end else if (stat_i.held) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_DUP;
            end else if (stat_i.cnt_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.push_init = 1'b1;
            end
          end
          OP_POP: begin
            if (stat_i.cnt_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_EMPTY;
            end else begin
              cmd_o.heap_rd = 1'b1;
              cmd_o.rd_sel  = RD_ZERO;
            end
          end
          OP_ADD, OP_FLAG, OP_WEIGHT: begin
            if (!stat_i.held) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NOT_FOUND;
            end else begin
              cmd_o.slot_rd = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_POP_RD: begin
        cmd_o.pop_take = 1'b1;
        cmd_o.heap_rd  = 1'b1;
        cmd_o.rd_sel   = RD_LAST;
      end
      S_POP_LAST: cmd_o.pop_last_ld = 1'b1;
      S_UPD_SLOT: begin
        cmd_o.upd_pos_ld = 1'b1;
        cmd_o.heap_rd    = 1'b1;
        cmd_o.rd_sel     = RD_SLOT;
      end
      S_UPD_RD: cmd_o.upd_e_ld = 1'b1;
      S_UP_RD: begin
        cmd_o.heap_rd = !stat_i.pos_zero;
        cmd_o.rd_sel  = RD_PARENT;
      end
      S_UP_CMP: cmd_o.up_move = stat_i.up_ahead;
      S_DN_L: begin
        cmd_o.heap_rd = stat_i.left_ok;
        cmd_o.rd_sel  = RD_LEFT;
      end
      S_DN_R: begin
        cmd_o.dn_left_ld = 1'b1;
        cmd_o.heap_rd    = stat_i.right_ok;
        cmd_o.rd_sel     = RD_RIGHT;
      end
      S_DN_CMP: cmd_o.dn_right_cmp = 1'b1;
      S_DN_DEC: cmd_o.dn_move = stat_i.child_better;
      S_WRITE:  cmd_o.e_write = 1'b1;
      S_TOP: begin
        cmd_o.heap_rd = !(stat_i.have_report || stat_i.cnt_zero);
        cmd_o.rd_sel  = RD_ZERO;
      end
      S_TOP_RD: cmd_o.top_ld = 1'b1;
      S_DONE:   cmd_o.out_ld = !stat_i.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/imh_dp.sv =====
// Datapath of the indexed min-heap: heap and id-to-slot memories, present bits,
// the moving entry, child compare, fill count and the output register.
// Depends on imh_pkg and imh_ram.
module imh_dp #(
  parameter int unsigned CAPACITY = imh_pkg::DefCapacity,
  parameter int unsigned ID_COUNT = imh_pkg::DefIdCount
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imh_pkg::ctrl_cmd_t cmd_i,
  output imh_pkg::dp_stat_t  stat_o,
  input  logic [2:0]         opcode_i,
  input  logic [7:0]         item_id_i,
  input  logic [15:0]        frequency_i,
  input  logic               new_flag_i,
  input  logic [15:0]        new_weight_i,
  input  logic [15:0]        freq_delta_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [2:0]         status_o,
  output logic [7:0]         out_id_o,
  output logic [15:0]        out_frequency_o,
  output logic               out_flag_o,
  output logic [15:0]        out_weight_o,
  output logic               is_empty_o,
  output logic [8:0]         entry_count_o
);
  import imh_pkg::*;

  localparam int unsigned SlotW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW  = $clog2(ID_COUNT);
  localparam int unsigned ChW   = SlotW + 2;

  opcode_e          op_q;
  logic [7:0]       id_q;
  logic [15:0]      freq_in_q, weight_in_q, add_q;
  logic             flag_in_q;
  logic [CntW-1:0]  cnt_q;
  logic [ID_COUNT-1:0] valid_q;
  logic [SlotW-1:0] pos_q, child_pos_q;
  entry_t           e_q, child_q, report_q;
  logic             child_better_q, have_q;
  status_e          status_q;
  logic             out_valid_q;
  entry_t           out_e_q;
  status_e          out_status_q;
  logic             out_empty_q;
  logic [8:0]       out_count_q;

  entry_t           heap_rdata, heap_wdata, best_e, upd_e;
  logic [SlotW-1:0] heap_raddr, heap_waddr, slot_rdata, parent;
  logic             heap_we, slot_we;
  logic [IdxW-1:0]  slot_waddr, id_idx, rd_idx;
  logic [IdxW+7:0]  id_ext, rd_ext, wr_ext;
  logic [ChW-1:0]   left_w, right_w, cnt_w;
  logic signed [17:0] sum;
  logic [15:0]      sat;
  logic             held, dir_up, dir_down;
  logic [CntW+8:0]  cnt_ext;

  assign id_ext = {{IdxW{1'b0}}, id_q};
  assign id_idx = id_ext[IdxW-1:0];
  assign rd_ext = {{IdxW{1'b0}}, heap_rdata.id};
  assign rd_idx = rd_ext[IdxW-1:0];
  assign held   = (id_ext < (IdxW + 8)'(ID_COUNT)) && valid_q[id_idx];

  assign parent  = SlotW'((pos_q - 1'b1) >> 1);
  assign left_w  = ChW'({pos_q, 1'b1});
  assign right_w = left_w + 1'b1;
  assign cnt_w   = ChW'(cnt_q);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ZERO:   heap_raddr = '0;
      RD_LAST:   heap_raddr = SlotW'(cnt_q - 1'b1);
      RD_PARENT: heap_raddr = parent;
      RD_LEFT:   heap_raddr = left_w[SlotW-1:0];
      RD_RIGHT:  heap_raddr = right_w[SlotW-1:0];
      RD_SLOT:   heap_raddr = slot_rdata;
      default:   heap_raddr = '0;
    endcase
  end

  // Only one of these moves is issued in a cycle; each writes the entry at pos.
  always_comb begin
    heap_we    = cmd_i.up_move || cmd_i.dn_move || cmd_i.e_write;
    heap_waddr = pos_q;
    if (cmd_i.up_move) heap_wdata = heap_rdata;
    else if (cmd_i.dn_move) heap_wdata = child_q;
    else heap_wdata = e_q;
    slot_we = heap_we;
  end

  assign wr_ext     = {{IdxW{1'b0}}, heap_wdata.id};
  assign slot_waddr = wr_ext[IdxW-1:0];

  imh_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .re_i    (cmd_i.heap_rd),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  imh_ram #(.WIDTH(SlotW), .DEPTH(ID_COUNT)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (pos_q),
    .re_i    (cmd_i.slot_rd),
    .raddr_i (id_idx),
    .rdata_o (slot_rdata)
  );

  // Frequency update saturates to the unsigned 16-bit range.
  assign sum = $signed({2'b00, heap_rdata.freq}) + $signed({{2{add_q[15]}}, add_q});
  always_comb begin
    if (sum[17]) sat = '0;
    else if (sum[16]) sat = '1;
    else sat = sum[15:0];
  end

  always_comb begin
    upd_e    = heap_rdata;
    dir_up   = 1'b0;
    dir_down = 1'b0;
    case (op_q)
      OP_ADD: begin
        upd_e.freq = sat;
        dir_up     = sat < heap_rdata.freq;
        dir_down   = !dir_up;
      end
      OP_FLAG: begin
        upd_e.flag = flag_in_q;
        dir_up     = flag_in_q && !heap_rdata.flag;
        dir_down   = !flag_in_q && heap_rdata.flag;
      end
      OP_WEIGHT: begin
        upd_e.weight = weight_in_q;
        dir_up       = weight_in_q < heap_rdata.weight;
        dir_down     = weight_in_q > heap_rdata.weight;
      end
      default: ;
    endcase
  end

  assign best_e = child_better_q ? child_q : e_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q        <= opcode_e'(opcode_i);
      id_q        <= item_id_i;
      freq_in_q   <= frequency_i;
      flag_in_q   <= new_flag_i;
      weight_in_q <= new_weight_i;
      add_q       <= freq_delta_i;
    end
    if (cmd_i.push_init) begin
      e_q   <= '{id: id_q, freq: freq_in_q, flag: flag_in_q, weight: weight_in_q};
      pos_q <= cnt_q[SlotW-1:0];
    end
    if (cmd_i.pop_last_ld) begin
      e_q   <= heap_rdata;
      pos_q <= '0;
    end
    if (cmd_i.upd_pos_ld) pos_q <= slot_rdata;
    if (cmd_i.upd_e_ld) e_q <= upd_e;
    if (cmd_i.up_move) pos_q <= parent;
    if (cmd_i.dn_left_ld) begin
      child_q        <= heap_rdata;
      child_pos_q    <= left_w[SlotW-1:0];
      child_better_q <= ranks_ahead(heap_rdata, e_q);
    end
    if (cmd_i.dn_right_cmp && ranks_ahead(heap_rdata, best_e)) begin
      child_q        <= heap_rdata;
      child_pos_q    <= right_w[SlotW-1:0];
      child_better_q <= 1'b1;
    end
    if (cmd_i.dn_move) pos_q <= child_pos_q;
    if (cmd_i.pop_take || cmd_i.top_ld) report_q <= heap_rdata;
    if (cmd_i.out_ld) begin
      out_e_q      <= have_q ? report_q : '0;
      out_status_q <= status_q;
      out_empty_q  <= (cnt_q == '0);
      out_count_q  <= cnt_ext[8:0];
    end
  end

  assign cnt_ext = {9'd0, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      valid_q     <= '0;
      have_q      <= 1'b0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ld_in) begin
        have_q   <= 1'b0;
        status_q <= ST_OK;
      end
      if (cmd_i.set_status) status_q <= cmd_i.status;
      if (cmd_i.push_init) begin
        cnt_q           <= cnt_q + 1'b1;
        valid_q[id_idx] <= 1'b1;
      end
      if (cmd_i.pop_take) begin
        cnt_q           <= cnt_q - 1'b1;
        valid_q[rd_idx] <= 1'b0;
        have_q          <= 1'b1;
      end
      if (cmd_i.top_ld) have_q <= 1'b1;
      if (cmd_i.out_ld) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    stat_o              = '0;
    stat_o.op           = op_q;
    stat_o.id_ok        = id_ext < (IdxW + 8)'(ID_COUNT);
    stat_o.held         = held;
    stat_o.cnt_zero     = (cnt_q == '0);
    stat_o.cnt_full     = (cnt_q >= CntW'(CAPACITY));
    stat_o.cnt_one      = (cnt_q == CntW'(1));
    stat_o.pos_zero     = (pos_q == '0);
    stat_o.left_ok      = left_w < cnt_w;
    stat_o.right_ok     = right_w < cnt_w;
    stat_o.up_ahead     = ranks_ahead(e_q, heap_rdata);
    stat_o.child_better = child_better_q;
    stat_o.dir_up       = dir_up;
    stat_o.dir_down     = dir_down;
    stat_o.have_report  = have_q;
    stat_o.out_busy     = out_valid_q && !out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign out_id_o        = out_e_q.id;
  assign out_frequency_o = out_e_q.freq;
  assign out_flag_o      = out_e_q.flag;
  assign out_weight_o    = out_e_q.weight;
  assign is_empty_o      = out_empty_q;
  assign entry_count_o   = out_count_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  a_push_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_init |-> !held && !stat_o.cnt_full)
    else $error("push of held id or into full heap");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |=> out_valid_q)
    else $error("result not presented after load");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_take |-> cnt_q != '0)
    else $error("pop from empty heap");

endmodule

// ===== hw/rtl/indexed_min_heap_three_key.sv =====
// Indexed binary min-heap with three sort keys (frequency, flag, weight).
// One transaction on the slave stream is one operation; its opcode travels in tuser
// (0 push, 1 pop, 2 add to frequency, 3 set flag, 4 set weight, others no operation).
// Each operation yields exactly one result transaction on the master stream, carrying
// the status in tuser and the popped or current top entry, an empty mark and the
// entry count in tdata.
// The block works on one operation at a time: tready is high only while it is idle.
// Each level an entry moves up takes a read of the parent, a compare and a write;
// each level it moves down takes reads of the left and right children, a compare and
// a write. The result becomes valid in the cycle in which tready rises again.
// Reset clears the fill count and all id present bits at once; no clearing pass runs.
// Results sit in an output register; a stalled receiver holds the result, and the
// following operation waits in its final step until the register is free.
// Depends on imh_pkg, imh_ctrl, imh_dp and imh_ram.
module indexed_min_heap_three_key #(
  parameter int unsigned CAPACITY = imh_pkg::DefCapacity,
  parameter int unsigned ID_COUNT = imh_pkg::DefIdCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // item_id[7:0], frequency[23:8], new_flag[24], new_weight[40:25], freq_delta[56:41]
  input  logic [63:0] s_axis_tdata,
  // opcode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_id[7:0], out_frequency[23:8], out_flag[24], out_weight[40:25],
  // is_empty[41], entry_count[50:42]
  output logic [55:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser
);
  import imh_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  logic [7:0]  out_id;
  logic [15:0] out_freq, out_weight;
  logic        out_flag, is_empty;
  logic [8:0]  entry_count;

  imh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  imh_dp #(.CAPACITY(CAPACITY), .ID_COUNT(ID_COUNT)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (s_axis_tuser),
    .item_id_i       (s_axis_tdata[7:0]),
    .frequency_i     (s_axis_tdata[23:8]),
    .new_flag_i      (s_axis_tdata[24]),
    .new_weight_i    (s_axis_tdata[40:25]),
    .freq_delta_i    (s_axis_tdata[56:41]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .status_o        (m_axis_tuser),
    .out_id_o        (out_id),
    .out_frequency_o (out_freq),
    .out_flag_o      (out_flag),
    .out_weight_o    (out_weight),
    .is_empty_o      (is_empty),
    .entry_count_o   (entry_count)
  );

  assign m_axis_tdata = {5'd0, entry_count, is_empty, out_weight, out_flag, out_freq, out_id};

endmodule
